### rtl/aip_pkg.sv
// Shared types, widths, character codes and the digit decoder for the ASCII integer parser.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package aip_pkg;

  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned RADIX_W           = 6;
  localparam int unsigned VALUE_W           = 64;
  localparam int unsigned OFFSET_W          = 8;
  localparam int unsigned DIGIT_W           = 7;
  localparam int unsigned MAX_CHARS_DEFAULT = 255;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

  localparam logic [DIGIT_W-1:0] NOT_ALNUM = 7'd64;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  // One character beat as it sits in the input register.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
  } aip_beat_t;

  // Value of a digit or letter (either case), NOT_ALNUM for anything else.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NOT_ALNUM;
    if (c inside {[8'h30:8'h39]}) begin
      d = DIGIT_W'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = DIGIT_W'(c - 8'h57);
    end else if (c inside {[8'h41:8'h5A]}) begin
      d = DIGIT_W'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

### rtl/ascii_integer_parser_unit.sv
// Top level of the streaming ASCII integer parser (strtol style conversion).
// Depends on aip_pkg, aip_in_stage and aip_parse_core.
`timescale 1ns / 1ps

// The parser takes a string one character per beat and returns one result beat for the
// beat marked end_of_string: the signed value, wrapped modulo 2^64, and the number of
// characters consumed before parsing stopped, saturating at MAX_CHARS and shown in its low
// eight bits. It accepts one character every clock cycle; the character step (digit decode,
// one multiply of the 64-bit accumulator by the 6-bit radix, and an add) is combinational
// logic between the input register and the parse state. A result is registered when the
// core takes the last character of its string. The only stall is when an end-of-string
// character reaches the core while the previous result is still waiting to be taken; other
// characters keep flowing regardless of the output side. The radix register is written
// through its own channel, which is always ready, and should only be changed between strings.

module ascii_integer_parser_unit #(
  parameter int unsigned MAX_CHARS = aip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aip_pkg::RADIX_W-1:0]          radix_select,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [aip_pkg::CHAR_W-1:0]           char_code,
  input  logic                                 end_of_string,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [aip_pkg::VALUE_W-1:0]   parsed_value,
  output logic [aip_pkg::OFFSET_W-1:0]         end_offset
);
  import aip_pkg::*;

  aip_beat_t beat_in;
  aip_beat_t beat;
  logic      beat_valid;
  logic      take;

  // Pack the incoming character beat for the input register.
  assign beat_in.char_code     = char_code;
  assign beat_in.end_of_string = end_of_string;

  // Input register: it is refilled in the same cycle that the core takes its beat, so a new
  // character is accepted every cycle while the core keeps up.
  aip_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .beat_in    (beat_in),
    .beat_valid (beat_valid),
    .beat       (beat),
    .take       (take)
  );

  // Parse core: holds the radix register, the parse state and the result register.
  aip_parse_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_parse_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .radix_select (radix_select),
    .beat_valid   (beat_valid),
    .beat         (beat),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .end_offset   (end_offset)
  );

endmodule

### rtl/aip_in_stage.sv
// Input register of the ASCII integer parser: holds one character beat for the parse core.
// Depends on aip_pkg for the beat type.
`timescale 1ns / 1ps

module aip_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aip_pkg::aip_beat_t beat_in,
  output logic              beat_valid,
  output aip_pkg::aip_beat_t beat,
  input  logic              take
);
  import aip_pkg::*;

  // The register refills in the same cycle that the core consumes it.
  assign in_ready = !beat_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        beat_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        beat <= beat_in;
      end
    end
  end

endmodule

### rtl/aip_parse_core.sv
// Parse state, combinational character step and result register of the ASCII integer parser.
// Depends on aip_pkg for widths, character codes, the beat type and the digit decoder.
`timescale 1ns / 1ps

module aip_parse_core #(
  parameter int unsigned MAX_CHARS = aip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aip_pkg::RADIX_W-1:0]   radix_select,
  input  logic                          beat_valid,
  input  aip_pkg::aip_beat_t            beat,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [aip_pkg::VALUE_W-1:0] parsed_value,
  output logic [aip_pkg::OFFSET_W-1:0]  end_offset
);
  import aip_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CHARS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  logic [RADIX_W-1:0] radix_cfg;
  phase_t             phase, phase_next;
  logic               is_negative, is_negative_next;
  logic [RADIX_W-1:0] active_radix, active_radix_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [POS_W-1:0]   char_position, char_position_next;
  logic [POS_W-1:0]   stop_position, stop_position_next;
  logic               halted, halted_next;

  logic [CHAR_W-1:0]  c;
  logic [DIGIT_W-1:0] dig;
  logic [RADIX_W-1:0] dig_radix, first_radix, zero_radix;
  logic               prefix_ok, take_first, dig_go, adv, stop;
  logic [VALUE_W-1:0] res_value;
  logic [POS_W-1:0]   res_pos;
  logic [POS_W+OFFSET_W-1:0] res_pos_ext;

  assign cfg_ready = 1'b1;
  assign take = beat_valid && (!beat.end_of_string || !out_valid || out_ready);

  assign c           = beat.char_code;
  assign dig         = digit_of(c);
  assign first_radix = (radix_cfg == RADIX_AUTO) ? RADIX_DEC : radix_cfg;
  assign zero_radix  = (radix_cfg == RADIX_AUTO) ? RADIX_OCT : radix_cfg;
  assign prefix_ok   = (radix_cfg == RADIX_AUTO) || (radix_cfg == RADIX_HEX);

  always_comb begin
    phase_next         = phase;
    is_negative_next   = is_negative;
    active_radix_next  = active_radix;
    accumulator_next   = accumulator;
    char_position_next = char_position;
    stop_position_next = stop_position;
    halted_next        = halted;
    take_first         = 1'b0;
    dig_go             = 1'b0;
    dig_radix          = active_radix;
    adv                = 1'b0;
    stop               = 1'b0;

    if (!halted) begin
      case (phase)
        PH_SPACE: begin
          if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
            adv = 1'b1;
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            is_negative_next = (c == CH_MINUS);
            phase_next       = PH_SIGNED;
            adv              = 1'b1;
          end else begin
            take_first = 1'b1;
          end
        end
        PH_SIGNED: begin
          take_first = 1'b1;
        end
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            active_radix_next = RADIX_HEX;
            phase_next        = PH_DIGITS;
            adv               = 1'b1;
          end else begin
            active_radix_next = zero_radix;
            phase_next        = PH_DIGITS;
            dig_go            = 1'b1;
            dig_radix         = zero_radix;
          end
        end
        PH_DIGITS: begin
          dig_go = 1'b1;
        end
        default: begin
          phase_next = PH_SPACE;
        end
      endcase

      if (take_first) begin
        if (c == CH_NUL) begin
          stop = 1'b1;
        end else if (c == CH_ZERO && prefix_ok) begin
          phase_next = PH_ZERO;
          adv        = 1'b1;
        end else begin
          active_radix_next = first_radix;
          phase_next        = PH_DIGITS;
          dig_go            = 1'b1;
          dig_radix         = first_radix;
        end
      end

      if (dig_go) begin
        if (c == CH_NUL || dig >= {1'b0, dig_radix}) begin
          stop = 1'b1;
        end else begin
          accumulator_next = accumulator * VALUE_W'(dig_radix) + VALUE_W'(dig);
          adv              = 1'b1;
        end
      end
    end

    if (stop) begin
      halted_next        = 1'b1;
      stop_position_next = char_position;
    end
    if (adv && char_position < POS_MAX) begin
      char_position_next = char_position + POS_W'(1);
    end

    res_value   = is_negative_next ? (~accumulator_next + VALUE_W'(1)) : accumulator_next;
    res_pos     = halted_next ? stop_position_next : char_position_next;
    res_pos_ext = {{OFFSET_W{1'b0}}, res_pos};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_cfg     <= RADIX_RESET;
      phase         <= PH_SPACE;
      is_negative   <= 1'b0;
      active_radix  <= '0;
      accumulator   <= '0;
      char_position <= '0;
      stop_position <= '0;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix_cfg <= radix_select;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (beat.end_of_string) begin
          phase         <= PH_SPACE;
          is_negative   <= 1'b0;
          active_radix  <= '0;
          accumulator   <= '0;
          char_position <= '0;
          stop_position <= '0;
          halted        <= 1'b0;
          out_valid     <= 1'b1;
          parsed_value  <= res_value;
          end_offset    <= res_pos_ext[OFFSET_W-1:0];
        end else begin
          phase         <= phase_next;
          is_negative   <= is_negative_next;
          active_radix  <= active_radix_next;
          accumulator   <= accumulator_next;
          char_position <= char_position_next;
          stop_position <= stop_position_next;
          halted        <= halted_next;
        end
      end
    end
  end

endmodule

### rtl/aip_checker.sv
// Port-level checks for the ASCII integer parser, bound to the top level.
// Depends on aip_pkg for port widths and on ascii_integer_parser_unit as the bind target.
`timescale 1ns / 1ps

module aip_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [aip_pkg::RADIX_W-1:0]        radix_select,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [aip_pkg::CHAR_W-1:0]         char_code,
  input logic                               end_of_string,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [aip_pkg::VALUE_W-1:0] parsed_value,
  input logic [aip_pkg::OFFSET_W-1:0]       end_offset
);

  // A stalled result beat keeps its payload.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(parsed_value) && $stable(end_offset))
    else $error("result beat changed while stalled");

  // A result beat only leaves once it has been taken.
  a_out_fall : assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result beat dropped without being taken");

  // The input side only stalls behind a result that is waiting to be taken.
  a_in_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // The radix register is always writable.
  a_cfg_ready : assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (.*);

### dv/aip_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the ASCII integer parser: a beat-level model of the parse and the results it owes.
// Depends on aip_pkg for widths, radix codes and character codes.

package aip_check_pkg;

  import aip_pkg::*;

  typedef enum logic [1:0] {
    LEAD_SPACE,
    AFTER_SIGN,
    ZERO_SEEN,
    IN_DIGITS
  } scan_phase_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [OFFSET_W-1:0]       offset;
  } parse_result_t;

  localparam logic [CHAR_W-1:0] CH_NINE    = "9";
  localparam logic [CHAR_W-1:0] CH_LOWER_A = "a";
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = "z";

  class integer_parse_scoreboard;

    logic [RADIX_W-1:0] radix_setting;
    scan_phase_t        phase;
    bit                 negative;
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] total;
    int unsigned        consumed;
    int unsigned        stopped_at;
    int unsigned        pos_limit;
    bit                 stopped;
    parse_result_t      expected_numbers[$];
    int unsigned        mismatches;

    function new(int unsigned max_chars);
      pos_limit     = max_chars;
      radix_setting = RADIX_RESET;
      mismatches    = 0;
      restart();
    endfunction

    function void restart();
      phase      = LEAD_SPACE;
      negative   = 1'b0;
      base       = '0;
      total      = '0;
      consumed   = 0;
      stopped_at = 0;
      stopped    = 1'b0;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] r);
      radix_setting = r;
    endfunction

    function int unsigned pending();
      return expected_numbers.size();
    endfunction

    // Folding bit 5 maps upper-case letters onto lower case and leaves no other byte in a-z.
    function int unsigned char_value(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] folded;
      folded = c | 8'h20;
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) return folded - CH_LOWER_A + 10;
      return NOT_ALNUM;
    endfunction

    function void bump();
      if (consumed < pos_limit) consumed++;
    endfunction

    function void halt_here();
      stopped    = 1'b1;
      stopped_at = consumed;
    endfunction

    function void take_digit(logic [CHAR_W-1:0] c);
      int unsigned d;
      d = char_value(c);
      if (c == CH_NUL || d >= base) begin
        halt_here();
      end else begin
        total = total * VALUE_W'(base) + VALUE_W'(d);
        bump();
      end
    endfunction

    function void take_first(logic [CHAR_W-1:0] c);
      if (c == CH_NUL) begin
        halt_here();
      end else if (c == CH_ZERO && (radix_setting == RADIX_AUTO || radix_setting == RADIX_HEX)) begin
        phase = ZERO_SEEN;
        bump();
      end else begin
        base  = (radix_setting == RADIX_AUTO) ? RADIX_DEC : radix_setting;
        phase = IN_DIGITS;
        take_digit(c);
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic last);
      parse_result_t res;
      if (!stopped) begin
        case (phase)
          LEAD_SPACE: begin
            if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
              bump();
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              negative = (c == CH_MINUS);
              phase    = AFTER_SIGN;
              bump();
            end else begin
              take_first(c);
            end
          end
          AFTER_SIGN: take_first(c);
          ZERO_SEEN: begin
            phase = IN_DIGITS;
            if (c == CH_LX || c == CH_UX) begin
              base = RADIX_HEX;
              bump();
            end else begin
              base  = (radix_setting == RADIX_AUTO) ? RADIX_OCT : radix_setting;
              total = '0;
              take_digit(c);
            end
          end
          default: take_digit(c);
        endcase
      end
      if (last) begin
        if (!stopped) stopped_at = consumed;
        res.value  = negative ? -total : total;
        res.offset = OFFSET_W'(stopped_at);
        expected_numbers.push_back(res);
        restart();
      end
    endfunction

    task report(string what);
      $display("%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [VALUE_W-1:0] got_value, logic [OFFSET_W-1:0] got_offset);
      parse_result_t want;
      if (expected_numbers.size() == 0) begin
        report($sformatf("unexpected result value %0d offset %0d", got_value, got_offset));
        return;
      end
      want = expected_numbers.pop_front();
      if (got_value !== want.value)
        report($sformatf("value %0d, expected %0d", got_value, want.value));
      if (got_offset !== want.offset)
        report($sformatf("offset %0d, expected %0d", got_offset, want.offset));
    endtask

  endclass

endpackage

### dv/tb_ascii_integer_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for ascii_integer_parser_unit: directed strings, then random ones per radix.
// Depends on aip_pkg, aip_check_pkg and the RTL of the parser.

// The run is split into phases, one per radix setting. Every phase ends with a full string, so
// the parser is back at its whitespace state when the sender drains and the radix is rewritten.
// Characters are driven on the falling edge; every handshake is observed on the rising edge by a
// single monitor, which feeds the scoreboard with accepted character beats, radix writes and
// result beats.

module tb_ascii_integer_parser_unit;

  import aip_pkg::*;
  import aip_check_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  // Longest correct quiet spell is a sender gap plus a receiver stall; the limit leaves a wide
  // margin on top of that.
  localparam int unsigned IDLE_LIMIT    = 2000;
  // A result is registered once the core takes its last beat; this covers that with room to spare.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Random characters per phase, not counting the one long string of some phases.
  localparam int unsigned PHASE_CHARS   = 64;

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      cfg_valid     = 1'b0;
  logic                      cfg_ready;
  logic [RADIX_W-1:0]        radix_select  = RADIX_AUTO;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [CHAR_W-1:0]         char_code     = CH_NUL;
  logic                      end_of_string = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic signed [VALUE_W-1:0] parsed_value;
  logic [OFFSET_W-1:0]       end_offset;

  integer_parse_scoreboard board;

  // Receiver pattern, an 8-bit mask replayed bit by bit, and the sender's pacing for the phase.
  logic [7:0]  ready_mask  = 8'hFF;
  logic [2:0]  stall_step  = 3'd0;
  bit          sender_paced = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  // Radix settings after the reset value: auto detection and the extremes of the field, the
  // radix that accepts only a zero, and radices above 36 that accept every digit and letter.
  logic [RADIX_W-1:0] radix_plan [11] = '{RADIX_AUTO, RADIX_HEX, RADIX_OCT, 6'd2, 6'd36, 6'd1,
                                          6'd63, 6'd37, 6'd7, RADIX_AUTO, RADIX_DEC};

  localparam logic [CHAR_W-1:0] CH_UPPER_A = "A";

  ascii_integer_parser_unit #(
    .MAX_CHARS(MAX_CHARS_DEFAULT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .radix_select (radix_select),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .end_offset   (end_offset)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver stalls on its own repeating pattern, independent of the sender.
  always @(negedge clk) begin
    out_ready  <= ready_mask[stall_step];
    stall_step <= stall_step + 3'd1;
  end

  // Monitor: every beat that completes a handshake goes to the scoreboard. The radix write is
  // handled first, although no character beat ever shares its edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_radix(radix_select);
      if (in_valid && in_ready) board.note_char(char_code, end_of_string);
      if (out_valid && out_ready) board.check_result(parsed_value, end_offset);
    end
  end

  // Watchdog: a run in which no channel moves a beat for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ascii_integer_parser_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one character beat. The sender works in bursts; when a burst runs out and the phase
  // is paced, valid drops for a random gap before the next burst starts.
  task automatic push_beat(input logic [CHAR_W-1:0] c, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_paced) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_string <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1);
  endtask

  // A valid digit of radix r in random case; r above 36 takes any digit or letter.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] r);
    int unsigned d;
    if (r >= 37) d = $urandom_range(0, 35);
    else if (r <= 1) d = 0;
    else d = $urandom_range(0, r - 1);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return (($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'(d - 10);
  endfunction

  // Most strings are well formed: blanks, an optional sign, sometimes a zero or a 0x prefix,
  // digits of the radix with the odd corrupt one, then an optional terminator and junk after
  // it. The rest are random bytes. A long string runs close to the position limit or past it.
  task automatic send_random_string(input logic [RADIX_W-1:0] r, input bit long_form,
                                    output int unsigned sent);
    logic [CHAR_W-1:0]  text[$];
    logic [CHAR_W-1:0]  blank;
    logic [RADIX_W-1:0] digit_base;
    int unsigned        ndigits;
    int unsigned        tail;
    digit_base = (r == RADIX_AUTO) ? RADIX_DEC : r;
    if (!long_form && $urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) text.push_back(CHAR_W'($urandom));
    end else begin
      repeat (long_form ? $urandom_range(100, 120) : $urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0:       blank = CH_SPACE;
          1:       blank = CH_TAB;
          2:       blank = CH_LF;
          default: blank = CH_CR;
        endcase
        text.push_back(blank);
      end
      case ($urandom_range(0, 2))
        1:       text.push_back(CH_PLUS);
        2:       text.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        text.push_back(CH_ZERO);
        if ($urandom_range(0, 3) != 0) begin
          text.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
          if (r == RADIX_AUTO) digit_base = RADIX_HEX;
        end
      end
      if (long_form) ndigits = $urandom_range(150, 165);
      else if ($urandom_range(0, 7) == 0) ndigits = $urandom_range(15, 26);
      else ndigits = $urandom_range(0, 10);
      repeat (ndigits)
        text.push_back(($urandom_range(0, 19) == 0) ? CHAR_W'($urandom) : digit_char(digit_base));
      tail = $urandom_range(0, 3);
      if (tail == 1) text.push_back(CH_NUL);
      else if (tail >= 2) text.push_back(CHAR_W'($urandom));
      if (tail != 0) repeat ($urandom_range(0, 3)) text.push_back(CHAR_W'($urandom));
    end
    if (text.size() == 0) text.push_back(CHAR_W'($urandom));
    foreach (text[i]) push_beat(text[i], i == text.size() - 1);
    sent = text.size();
  endtask

  task automatic run_random(input logic [RADIX_W-1:0] r, input bit with_long);
    int unsigned total;
    int unsigned sent;
    total = 0;
    if (with_long) send_random_string(r, 1'b1, sent);
    while (total < PHASE_CHARS) begin
      send_random_string(r, 1'b0, sent);
      total += sent;
    end
  endtask

  // The sender holds off until every owed result has arrived, then lets the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    radix_select <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    board = new(MAX_CHARS_DEFAULT);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset radix of ten. A lone NUL and a lone 0xFF give no digits; the signed string stops
    // at a letter and ignores the beat after it; the carriage return case ends without a NUL;
    // a blank and a sign with nothing after them give zero with the offset past the sign.
    push_beat(CH_NUL, 1'b1);
    push_beat(8'hFF, 1'b1);
    send_text("-9z5");
    send_text("\015+5");
    send_text(" -");
    run_random(RADIX_RESET, 1'b1);

    foreach (radix_plan[p]) begin
      drain_results();
      // Odd phases run with the receiver always ready; the rest stall on a random pattern
      // that keeps at least one ready and one stalled cycle. Every third phase has no gaps.
      ready_mask   = (p % 2 != 0) ? 8'hFF : ((8'($urandom) | 8'h01) & 8'h7F);
      sender_paced = (p % 3 != 1);
      write_radix(radix_plan[p]);
      if (p == 0) begin
        // Auto detection: a prefix with no digits after it, a lone zero, octal, hex with an upper-case prefix.
        send_text("0x");
        send_text("0");
        send_text("017");
        send_text("0XfF");
      end
      run_random(radix_plan[p], p == 0);
    end

    drain_results();
    if (board.mismatches == 0) begin
      $display("ascii_integer_parser_unit regression: pass");
    end else begin
      $display("ascii_integer_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

### ascii_integer_parser_unit.f
rtl/aip_pkg.sv
rtl/aip_in_stage.sv
rtl/aip_parse_core.sv
rtl/ascii_integer_parser_unit.sv
rtl/aip_checker.sv
dv/aip_check_pkg.sv
dv/tb_ascii_integer_parser_unit.sv
